>>> rtl/esmp_pkg.sv
`default_nettype none

package esmp_pkg;

    // default sizes
    localparam int ESMP_TIME_WIDTH = 32;
    localparam int ESMP_FRAC_BITS  = 8;

    // configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_ANGLE_MIN    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ANGLE_MAX    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ANGLE_DOWN   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ANGLE_UP     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_DETACH_LIMIT = 3'd4;

    localparam logic [7:0]  RST_ANGLE_MIN    = 8'd0;
    localparam logic [7:0]  RST_ANGLE_MAX    = 8'd180;
    localparam logic [7:0]  RST_ANGLE_DOWN   = 8'd10;
    localparam logic [7:0]  RST_ANGLE_UP     = 8'd170;
    localparam logic [15:0] RST_DETACH_LIMIT = 16'd1500;

    // item modes
    localparam logic [1:0] MODE_TICK   = 2'd0;
    localparam logic [1:0] MODE_PRESET = 2'd1;
    localparam logic [1:0] MODE_START  = 2'd2;
    localparam logic [1:0] MODE_RSVD   = 2'd3;

    // preset codes
    localparam logic [2:0] PRESET_DOWN = 3'd0;
    localparam logic [2:0] PRESET_UP   = 3'd1;
    localparam logic [2:0] PRESET_HALF = 3'd2;
    localparam logic [2:0] PRESET_WAVE = 3'd3;

    // move durations in ms
    localparam int DUR_W = 10;
    localparam logic [DUR_W-1:0] DUR_UPDOWN     = 10'd700;
    localparam logic [DUR_W-1:0] DUR_HALF       = 10'd800;
    localparam logic [DUR_W-1:0] DUR_WAVE_FIRST = 10'd400;
    localparam logic [DUR_W-1:0] DUR_WAVE_LEG   = 10'd300;
    localparam logic [DUR_W-1:0] DUR_RETURN     = 10'd600;
    localparam logic [2:0]       WAVE_LEGS      = 3'd6;

    // serial datapath sizes
    localparam int T_BITS = 16;
    localparam int S_BITS = 17;
    localparam int CNT_W  = 5;
    localparam logic [CNT_W-1:0] DIV_LAST = 5'd15;
    localparam logic [CNT_W-1:0] MUL_LAST = 5'd16;
    localparam logic [18:0]      U_BASE   = 19'd196608;

    typedef struct packed {
        logic [1:0]  mode;
        logic [2:0]  preset_code;
        logic [31:0] time_ms;
    } in_item_t;

    typedef struct packed {
        logic [7:0] angle;
        logic       servo_write;
        logic       attached;
        logic       moving;
        logic       preset_ok;
    } out_item_t;

endpackage

`default_nettype wire

>>> rtl/eased_servo_motion_profiler.sv
// eased servo motion profiler
// input channel in_valid / in_stall / in_data carries one item: a start, a
// preset command or a time tick. each item gives exactly one result on the
// output channel out_valid / out_stall / out_data (angle and status flags).
// configuration: cfg_wr_en with cfg_index and cfg_data writes one register
// at a rising edge; write only while no item is in flight.
// start, preset, idle and finishing ticks pass S_EVAL, then S_OUT, which
// loads the output register; a tick inside a move runs the bit-serial
// datapath in between: a 16-step restoring divider for t = elapsed/duration,
// then one shift-add multiplier run 17 steps each for t*t, t2*(3-2t) and the
// angle span times s, with a load step in S_NEXT before each run and after
// the last; the block works on one item at a time.
// in_stall is high while an item is being worked on; the next item is taken
// as soon as the result sits in the output register, even if it waits there.
// when the receiver stalls, the result holds in the output register and a
// following item is held back at its last cycle until the register frees.
// reset clears the motion state, loads the configuration defaults and drops
// out_valid; the block accepts an item in the first cycle after reset.
`default_nettype none

module eased_servo_motion_profiler
    import esmp_pkg::*;
#(
    parameter int TIME_WIDTH      = ESMP_TIME_WIDTH,
    parameter int ANGLE_FRAC_BITS = ESMP_FRAC_BITS
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire in_item_t               in_data,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output out_item_t                   out_data,
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int F  = ANGLE_FRAC_BITS;
    localparam int AW = 8 + F;
    localparam int MA = (AW + 1 > 19) ? AW + 1 : 19;
    localparam int PW = MA + S_BITS;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EVAL = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_NEXT = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    localparam logic [1:0] PH_SQ    = 2'd0;
    localparam logic [1:0] PH_CUBE  = 2'd1;
    localparam logic [1:0] PH_SCALE = 2'd2;
    localparam logic [1:0] PH_DONE  = 2'd3;

    // configuration
    logic [7:0]  min_reg, max_reg, down_reg, up_reg;
    logic [15:0] limit_reg;

    // motion state
    logic [AW-1:0]         cur_reg, cur_next;
    logic [AW-1:0]         start_reg, start_next;
    logic [7:0]            target_reg, target_next;
    logic [TIME_WIDTH-1:0] mstart_reg, mstart_next;
    logic [DUR_W-1:0]      dur_reg, dur_next;
    logic [TIME_WIDTH-1:0] idle_reg, idle_next;
    logic                  drive_reg, drive_next;
    logic                  waving_reg, waving_next;
    logic [2:0]            legs_reg, legs_next;
    logic                  high_reg, high_next;

    // control
    logic [2:0]       state_reg, state_next;
    logic [1:0]       phase_reg, phase_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             wr_reg, wr_next;
    logic             ok_reg, ok_next;
    logic             out_valid_reg, out_valid_next;

    // payload
    logic [1:0]            mode_reg;
    logic [2:0]            code_reg;
    logic [TIME_WIDTH-1:0] now_reg;
    logic [DUR_W-1:0]      rem_reg, rem_next;
    logic [T_BITS-1:0]     q_reg, q_next;
    logic [MA-1:0]         hi_reg, hi_next;
    logic [S_BITS-1:0]     lo_reg, lo_next;
    logic [MA-1:0]         mc_reg, mc_next;
    out_item_t             out_reg, out_next;

    logic                  accept;
    logic [63:0]           time_ext;
    logic [TIME_WIDTH-1:0] elapsed;
    logic [8:0]            mid_sum;
    logic [7:0]            mid_angle;
    logic [DUR_W:0]        div_shift;
    logic                  div_bit;
    logic [MA:0]           mul_sum;
    logic [PW-1:0]         prod;
    logic [18:0]           u_val;
    logic signed [AW:0]    diff;
    logic [AW:0]           round_sum;
    logic                  mv_go;
    logic [7:0]            mv_angle;
    logic [DUR_W-1:0]      mv_dur;

    function automatic logic [7:0] clamp_angle(
        input logic [7:0] a,
        input logic [7:0] lo_lim,
        input logic [7:0] hi_lim
    );
        logic [7:0] r;
        priority if (a < lo_lim) r = lo_lim;
        else if (a > hi_lim)     r = hi_lim;
        else                     r = a;
        return r;
    endfunction

    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign time_ext  = {32'b0, in_data.time_ms};

    // shared time subtractor: move time while moving, else idle time
    assign elapsed = now_reg - ((dur_reg != '0) ? mstart_reg : idle_reg);

    assign mid_sum   = {1'b0, down_reg} + {1'b0, up_reg};
    assign mid_angle = mid_sum[8:1];

    // one restoring divide step
    assign div_shift = {rem_reg, 1'b0};
    assign div_bit   = (div_shift >= {1'b0, dur_reg});

    // one signed shift-add multiply step
    assign mul_sum = {hi_reg[MA-1], hi_reg}
                   + (lo_reg[0] ? {mc_reg[MA-1], mc_reg} : '0);
    assign prod    = {hi_reg, lo_reg};

    assign u_val     = U_BASE - {2'b00, q_reg, 1'b0};
    assign diff      = signed'({1'b0, target_reg, {F{1'b0}}}) - signed'({1'b0, start_reg});
    assign round_sum = {1'b0, cur_reg} + (AW+1)'(1 << (F - 1));

    // next state and datapath
    always_comb
    begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        cnt_next    = cnt_reg;
        wr_next     = wr_reg;
        ok_next     = ok_reg;
        cur_next    = cur_reg;
        start_next  = start_reg;
        target_next = target_reg;
        mstart_next = mstart_reg;
        dur_next    = dur_reg;
        idle_next   = idle_reg;
        drive_next  = drive_reg;
        waving_next = waving_reg;
        legs_next   = legs_reg;
        high_next   = high_reg;
        rem_next    = rem_reg;
        q_next      = q_reg;
        hi_next     = hi_reg;
        lo_next     = lo_reg;
        mc_next     = mc_reg;
        out_next    = out_reg;
        mv_go       = 1'b0;
        mv_angle    = down_reg;
        mv_dur      = DUR_UPDOWN;
        out_valid_next = out_valid_reg && out_stall;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                wr_next    = 1'b0;
                ok_next    = 1'b0;
                state_next = S_OUT;
                unique case (mode_reg)
                    MODE_START:
                    begin
                        cur_next    = {down_reg, {F{1'b0}}};
                        start_next  = {down_reg, {F{1'b0}}};
                        target_next = down_reg;
                        dur_next    = '0;
                        waving_next = 1'b0;
                        drive_next  = 1'b1;
                        idle_next   = now_reg;
                        wr_next     = 1'b1;
                    end
                    MODE_PRESET:
                    begin
                        waving_next = 1'b0;
                        ok_next     = 1'b1;
                        unique case (code_reg)
                            PRESET_DOWN:
                            begin
                                mv_go    = 1'b1;
                                mv_angle = down_reg;
                                mv_dur   = DUR_UPDOWN;
                            end
                            PRESET_UP:
                            begin
                                mv_go    = 1'b1;
                                mv_angle = up_reg;
                                mv_dur   = DUR_UPDOWN;
                            end
                            PRESET_HALF:
                            begin
                                mv_go    = 1'b1;
                                mv_angle = mid_angle;
                                mv_dur   = DUR_HALF;
                            end
                            PRESET_WAVE:
                            begin
                                waving_next = 1'b1;
                                legs_next   = WAVE_LEGS;
                                high_next   = 1'b1;
                                mv_go       = 1'b1;
                                mv_angle    = up_reg;
                                mv_dur      = DUR_WAVE_FIRST;
                            end
                            default:
                            begin
                                ok_next = 1'b0;
                            end
                        endcase
                    end
                    MODE_TICK:
                    begin
                        if (dur_reg != '0)
                        begin
                            drive_next = 1'b1;
                            wr_next    = 1'b1;
                            if (elapsed >= TIME_WIDTH'(dur_reg))
                            begin
                                // leg done: land on target, chain wave leg or return
                                cur_next  = {target_reg, {F{1'b0}}};
                                dur_next  = '0;
                                idle_next = now_reg;
                                if (waving_reg && legs_reg != '0)
                                begin
                                    legs_next = legs_reg - 3'd1;
                                    high_next = !high_reg;
                                    mv_go     = 1'b1;
                                    mv_angle  = high_reg ? mid_angle : up_reg;
                                    mv_dur    = DUR_WAVE_LEG;
                                end
                                else if (waving_reg)
                                begin
                                    waving_next = 1'b0;
                                    mv_go       = 1'b1;
                                    mv_angle    = down_reg;
                                    mv_dur      = DUR_RETURN;
                                end
                            end
                            else
                            begin
                                // elapsed is below the duration, so it fits its width
                                rem_next   = elapsed[DUR_W-1:0];
                                cnt_next   = '0;
                                state_next = S_DIV;
                            end
                        end
                        else if (drive_reg && elapsed > TIME_WIDTH'(limit_reg))
                        begin
                            drive_next = 1'b0;
                        end
                    end
                    MODE_RSVD:
                    begin
                    end
                endcase
            end
            S_DIV:
            begin
                rem_next = div_bit ? DUR_W'(div_shift - {1'b0, dur_reg})
                                   : div_shift[DUR_W-1:0];
                q_next   = {q_reg[T_BITS-2:0], div_bit};
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == DIV_LAST)
                begin
                    phase_next = PH_SQ;
                    state_next = S_NEXT;
                end
            end
            S_MUL:
            begin
                hi_next  = mul_sum[MA:1];
                lo_next  = {mul_sum[0], lo_reg[S_BITS-1:1]};
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == MUL_LAST)
                begin
                    state_next = S_NEXT;
                end
            end
            S_NEXT:
            begin
                hi_next    = '0;
                cnt_next   = '0;
                state_next = S_MUL;
                unique case (phase_reg)
                    PH_SQ:
                    begin
                        mc_next    = MA'(q_reg);
                        lo_next    = S_BITS'(q_reg);
                        phase_next = PH_CUBE;
                    end
                    PH_CUBE:
                    begin
                        // t2 times (3 - 2t)
                        mc_next    = MA'(u_val);
                        lo_next    = S_BITS'(prod[31:16]);
                        phase_next = PH_SCALE;
                    end
                    PH_SCALE:
                    begin
                        // angle span times s
                        mc_next    = MA'(diff);
                        lo_next    = prod[32:16];
                        phase_next = PH_DONE;
                    end
                    PH_DONE:
                    begin
                        // floor of the signed product over 2^16
                        cur_next   = start_reg + prod[AW+15:16];
                        state_next = S_OUT;
                    end
                endcase
            end
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_next.angle       = round_sum[AW-1:F];
                    out_next.servo_write = wr_reg;
                    out_next.attached    = drive_reg;
                    out_next.moving      = (dur_reg != '0);
                    out_next.preset_ok   = ok_reg;
                    out_valid_next       = 1'b1;
                    state_next           = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // start a timed move from the angle just reached
        if (mv_go)
        begin
            target_next = clamp_angle(mv_angle, min_reg, max_reg);
            start_next  = cur_next;
            mstart_next = now_reg;
            dur_next    = mv_dur;
            drive_next  = 1'b1;
        end
    end

    // control, motion state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_SQ;
            cnt_reg       <= '0;
            wr_reg        <= 1'b0;
            ok_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            cur_reg       <= '0;
            start_reg     <= '0;
            target_reg    <= '0;
            mstart_reg    <= '0;
            dur_reg       <= '0;
            idle_reg      <= '0;
            drive_reg     <= 1'b0;
            waving_reg    <= 1'b0;
            legs_reg      <= '0;
            high_reg      <= 1'b0;
            min_reg       <= RST_ANGLE_MIN;
            max_reg       <= RST_ANGLE_MAX;
            down_reg      <= RST_ANGLE_DOWN;
            up_reg        <= RST_ANGLE_UP;
            limit_reg     <= RST_DETACH_LIMIT;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
            wr_reg        <= wr_next;
            ok_reg        <= ok_next;
            out_valid_reg <= out_valid_next;
            cur_reg       <= cur_next;
            start_reg     <= start_next;
            target_reg    <= target_next;
            mstart_reg    <= mstart_next;
            dur_reg       <= dur_next;
            idle_reg      <= idle_next;
            drive_reg     <= drive_next;
            waving_reg    <= waving_next;
            legs_reg      <= legs_next;
            high_reg      <= high_next;
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    REG_ANGLE_MIN:    min_reg   <= cfg_data[7:0];
                    REG_ANGLE_MAX:    max_reg   <= cfg_data[7:0];
                    REG_ANGLE_DOWN:   down_reg  <= cfg_data[7:0];
                    REG_ANGLE_UP:     up_reg    <= cfg_data[7:0];
                    REG_DETACH_LIMIT: limit_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // item capture and serial datapath
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg <= in_data.mode;
            code_reg <= in_data.preset_code;
            now_reg  <= time_ext[TIME_WIDTH-1:0];
        end
        rem_reg <= rem_next;
        q_reg   <= q_next;
        hi_reg  <= hi_next;
        lo_reg  <= lo_next;
        mc_reg  <= mc_next;
        out_reg <= out_next;
    end

`ifndef SYNTH
    // a transfer always leads into evaluation
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == S_EVAL)
        else $error("accepted item did not enter evaluation");

    // a pending move always keeps the drive on
    assert property (@(posedge clk) disable iff (!rst_n)
        dur_reg != '0 |-> drive_reg)
        else $error("move pending with drive off");

    // waving always has a leg in progress
    assert property (@(posedge clk) disable iff (!rst_n)
        waving_reg |-> dur_reg != '0)
        else $error("waving without a move");

    // divider remainder stays below the divisor
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> rem_reg < dur_reg)
        else $error("divider remainder out of range");

    // wave leg count never exceeds its load value
    assert property (@(posedge clk) disable iff (!rst_n)
        legs_reg <= WAVE_LEGS)
        else $error("wave leg count out of range");
`endif

endmodule

`default_nettype wire
